// ----- src/rlni_pkg.sv -----
// rlni_pkg: shared types, constants and helper functions for the ring lattice
// neighbor id block. Used by rlni_front, rlni_queue, rlni_back and the top level.
// No dependencies.
`timescale 1ns / 1ps

package rlni_pkg;

	localparam int DEF_ID_BITS = 20;
	localparam int OUT_W       = 21;
	localparam int BASE_W      = 8;
	localparam int POS_W       = 7;
	localparam int QDEPTH      = 2;

	localparam logic [BASE_W-1:0] BASE_RESET = 8'd12;
	localparam logic [BASE_W-1:0] BASE_MIN   = 8'd2;

	localparam logic [1:0] KIND_SAME  = 2'd0;
	localparam logic [1:0] KIND_INNER = 2'd1;
	localparam logic [1:0] KIND_OUTER = 2'd2;

	typedef struct packed {
		logic             bad;
		logic             has_inner;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] size;
		logic [OUT_W-1:0] start;
		logic [OUT_W-1:0] inner_nbr;
		logic [OUT_W-1:0] outer_nbr;
	} desc_t;

	// one 4-bit digit of a running remainder modulo 100, MSB first
	function automatic logic [POS_W-1:0] mod100_step(input logic [POS_W-1:0] r,
		input logic [3:0] d);
		logic [POS_W:0]   t;
		logic [POS_W-1:0] acc;
		acc = r;
		for (int i = 3; i >= 0; i--) begin
			t = {acc, d[i]};
			if (t >= 8'd100) begin
				t = t - 8'd100;
			end
			acc = t[POS_W-1:0];
		end
		return acc;
	endfunction

	// remainder modulo 12 of a value below 60
	function automatic logic [POS_W-1:0] mod12_small(input logic [POS_W-1:0] p);
		logic [POS_W-1:0] r;
		if (p >= 7'd48) begin
			r = p - 7'd48;
		end else if (p >= 7'd36) begin
			r = p - 7'd36;
		end else if (p >= 7'd24) begin
			r = p - 7'd24;
		end else if (p >= 7'd12) begin
			r = p - 7'd12;
		end else begin
			r = p;
		end
		return r;
	endfunction

endpackage

// ----- src/rlni_front.sv -----
// rlni_front: input side. Holds the base register, reduces the id modulo 100
// one 4-bit digit per cycle and classifies it into a ring descriptor.
// Depends on rlni_pkg.
`timescale 1ns / 1ps

module rlni_front
	import rlni_pkg::*;
#(
	parameter int ID_BITS = DEF_ID_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [ID_BITS-1:0] thread_number,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [BASE_W-1:0]  cfg_data,
	output logic               desc_valid,
	input  logic               desc_ready,
	output desc_t              desc
);

	localparam int NDIG = (ID_BITS + 3) / 4;
	localparam int PADW = NDIG * 4;
	localparam int CW   = $clog2(NDIG);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]         state_q;
	logic [BASE_W-1:0]  base_q;
	logic [ID_BITS-1:0] id_q;
	logic [PADW-1:0]    sh_q;
	logic [POS_W-1:0]   rem_q;
	logic [CW-1:0]      cnt_q;
	logic               bad_q;

	logic               accept;
	logic               is_small;
	logic [7:0]         lo;
	logic [OUT_W-1:0]   id_w;
	logic [POS_W-1:0]   ext_pos;

	assign cfg_ready  = 1'b1;
	assign desc_valid = (state_q == ST_DONE);
	assign full       = (state_q != ST_IDLE) && !(state_q == ST_DONE && desc_ready);
	assign accept     = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (accept) begin
			state_q <= (base_q < BASE_MIN) ? ST_DONE : ST_RUN;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (desc_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= state_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q  <= thread_number;
			sh_q  <= PADW'(thread_number);
			rem_q <= '0;
			cnt_q <= CW'(NDIG - 1);
			bad_q <= (base_q < BASE_MIN);
		end else if (state_q == ST_RUN) begin
			rem_q <= mod100_step(rem_q, sh_q[PADW-1 -: 4]);
			sh_q  <= sh_q << 4;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign lo       = id_q[7:0];
	assign is_small = (id_q < ID_BITS'(232));
	assign id_w     = OUT_W'(id_q);
	// ring 4 starts at 232, so the position is (id mod 100 - 32) mod 100
	assign ext_pos  = (rem_q >= 7'd32) ? (rem_q - 7'd32) : (rem_q + 7'd68);

	always_comb begin
		desc           = '0;
		desc.bad       = bad_q;
		desc.has_inner = 1'b1;
		if (!is_small) begin
			desc.pos       = ext_pos;
			desc.size      = 7'd100;
			desc.start     = id_w - OUT_W'(ext_pos);
			desc.inner_nbr = id_w - OUT_W'(100);
			desc.outer_nbr = id_w + OUT_W'(100);
		end else if (lo < 8'd12) begin
			desc.has_inner = 1'b0;
			desc.pos       = lo[POS_W-1:0];
			desc.size      = 7'd12;
			desc.start     = '0;
			desc.outer_nbr = OUT_W'(lo) + OUT_W'(12);
		end else if (lo < 8'd72) begin
			desc.pos       = POS_W'(lo - 8'd12);
			desc.size      = 7'd60;
			desc.start     = OUT_W'(12);
			desc.inner_nbr = OUT_W'(mod12_small(POS_W'(lo - 8'd12)));
			desc.outer_nbr = OUT_W'(lo) + OUT_W'(60);
		end else if (lo < 8'd132) begin
			desc.pos       = POS_W'(lo - 8'd72);
			desc.size      = 7'd60;
			desc.start     = OUT_W'(72);
			desc.inner_nbr = OUT_W'(lo) - OUT_W'(60);
			desc.outer_nbr = OUT_W'(lo) + OUT_W'(60);
		end else begin
			desc.pos       = POS_W'(lo - 8'd132);
			desc.size      = 7'd100;
			desc.start     = OUT_W'(132);
			desc.inner_nbr = (lo >= 8'd192) ? (OUT_W'(lo) - OUT_W'(120))
				: (OUT_W'(lo) - OUT_W'(60));
			desc.outer_nbr = OUT_W'(lo) + OUT_W'(100);
		end
	end

`ifndef SYNTHESIS
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && base_q >= BASE_MIN |=> full)
		else $error("front took a new transaction while reducing the last one");
`endif

endmodule

// ----- src/rlni_queue.sv -----
// rlni_queue: short descriptor queue between front and back.
// Depends on rlni_pkg (desc_t, QDEPTH).
`timescale 1ns / 1ps

module rlni_queue
	import rlni_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  desc_t wr_data,
	output logic  rd_valid,
	input  logic  rd_pop,
	output desc_t rd_data
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	desc_t            mem_q [QDEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr_en;
	logic             rd_en;

	assign wr_ready = (cnt_q != CNT_W'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_pop && rd_valid;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= (wp_q == PTR_W'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= (rp_q == PTR_W'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QDEPTH))
		else $error("descriptor queue count out of range");
`endif

endmodule

// ----- src/rlni_back.sv -----
// rlni_back: result sequencer. Walks one descriptor through its neighbor results,
// one per cycle into a result register while it is free or popped. Depends on rlni_pkg.
`timescale 1ns / 1ps

module rlni_back
	import rlni_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             desc_valid,
	output logic             desc_pop,
	input  desc_t            desc,
	output logic             empty,
	input  logic             pop,
	output logic [OUT_W-1:0] nbr_id,
	output logic [1:0]       neighbor_kind,
	output logic             bad_base,
	output logic             is_last
);

	localparam logic [2:0] STEP_FIRST     = 3'd0;
	localparam logic [2:0] STEP_LAST_SAME = 3'd5;
	localparam logic [2:0] STEP_INNER     = 3'd6;
	localparam logic [2:0] STEP_OUTER     = 3'd7;

	logic [2:0]       step_q;
	logic             oval_q;
	logic [OUT_W-1:0] id_q;
	logic [1:0]       kind_q;
	logic             bad_q;
	logic             last_q;

	logic             issue;
	logic             last_now;
	logic [POS_W-1:0] d;
	logic [POS_W:0]   sum;
	logic [POS_W-1:0] np;
	logic [OUT_W-1:0] id_n;
	logic [1:0]       kind_n;

	assign issue    = desc_valid && (!oval_q || pop);
	assign last_now = desc.bad || (step_q == STEP_OUTER);
	assign desc_pop = issue && last_now;

	always_comb begin
		d   = (step_q < 3'd3) ? POS_W'(3'd3 - step_q) : POS_W'(step_q - 3'd2);
		sum = '0;
		if (step_q < 3'd3) begin
			if (desc.pos >= d) begin
				np = desc.pos - d;
			end else begin
				np = desc.pos + desc.size - d;
			end
		end else begin
			sum = {1'b0, desc.pos} + {1'b0, d};
			if (sum >= {1'b0, desc.size}) begin
				np = POS_W'(sum - {1'b0, desc.size});
			end else begin
				np = sum[POS_W-1:0];
			end
		end
	end

	always_comb begin
		if (desc.bad) begin
			id_n   = '0;
			kind_n = KIND_SAME;
		end else begin
			case (step_q)
				STEP_INNER: begin
					id_n   = desc.inner_nbr;
					kind_n = KIND_INNER;
				end
				STEP_OUTER: begin
					id_n   = desc.outer_nbr;
					kind_n = KIND_OUTER;
				end
				default: begin
					id_n   = desc.start + OUT_W'(np);
					kind_n = KIND_SAME;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_FIRST;
			oval_q <= 1'b0;
		end else begin
			if (issue) begin
				oval_q <= 1'b1;
			end else if (pop) begin
				oval_q <= 1'b0;
			end
			if (issue) begin
				if (last_now) begin
					step_q <= STEP_FIRST;
				end else if (step_q == STEP_LAST_SAME && !desc.has_inner) begin
					step_q <= STEP_OUTER;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			id_q   <= id_n;
			kind_q <= kind_n;
			bad_q  <= desc.bad;
			last_q <= last_now;
		end
	end

	assign empty         = !oval_q;
	assign nbr_id        = id_q;
	assign neighbor_kind = kind_q;
	assign bad_base      = bad_q;
	assign is_last       = last_q;

`ifndef SYNTHESIS
	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		oval_q && bad_q |-> last_q)
		else $error("error result not marked last");
	a_inner_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		oval_q && kind_q == KIND_INNER |-> !last_q)
		else $error("inner neighbor marked last");
	a_outer_last: assert property (@(posedge clk) disable iff (!arst_n)
		oval_q && kind_q == KIND_OUTER |-> last_q)
		else $error("outer neighbor not marked last");
`endif

endmodule

// ----- src/ring_lattice_neighbor_ids.sv -----
// Channel   Dir  Handshake              Payload
// input     in   push / full            thread_number
// result    out  empty / pop            nbr_id, neighbor_kind, bad_base, is_last
// config    in   cfg_valid / cfg_ready  cfg_data (symmetry_base)
//
// Front reduces the id mod 100 one 4-bit digit per cycle and takes no new id
// until its descriptor is handed to the queue; a bad base skips the reduction. Back
// emits one result per cycle while the result register is free or being popped: 8 per
// transaction, 7 in ring 0, 1 on a bad base. The slower side sets the sustained
// rate. A two-entry queue and the result register let each side stall.
// Reset: symmetry_base = 12, queue and result register empty.
// Depends on rlni_pkg, rlni_front, rlni_queue, rlni_back.
`timescale 1ns / 1ps

module ring_lattice_neighbor_ids
	import rlni_pkg::*;
#(
	parameter int ID_BITS = DEF_ID_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [ID_BITS-1:0] thread_number,
	output logic               empty,
	input  logic               pop,
	output logic [OUT_W-1:0]   nbr_id,
	output logic [1:0]         neighbor_kind,
	output logic               bad_base,
	output logic               is_last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [BASE_W-1:0]  cfg_data
);

	logic  f_valid;
	logic  f_ready;
	desc_t f_desc;
	logic  b_valid;
	logic  b_pop;
	desc_t b_desc;

	rlni_front #(
		.ID_BITS(ID_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.thread_number(thread_number),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.desc_valid   (f_valid),
		.desc_ready   (f_ready),
		.desc         (f_desc)
	);

	rlni_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data (f_desc),
		.rd_valid(b_valid),
		.rd_pop  (b_pop),
		.rd_data (b_desc)
	);

	rlni_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.desc_valid   (b_valid),
		.desc_pop     (b_pop),
		.desc         (b_desc),
		.empty        (empty),
		.pop          (pop),
		.nbr_id       (nbr_id),
		.neighbor_kind(neighbor_kind),
		.bad_base     (bad_base),
		.is_last      (is_last)
	);

endmodule
